### design/ist_pkg.sv
// ist_pkg: shared types and codes for the integer set table
// request/response payloads, action and status codes
// no dependencies
package ist_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned POS_OUT_W   = 4;
  localparam int unsigned COUNT_OUT_W = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [POS_OUT_W-1:0]   position;
    logic [COUNT_OUT_W-1:0] count;
  } rsp_t;

  // update strobes broadcast to every cell
  typedef struct packed {
    logic cmp; // compare on the incoming request
    logic ins; // write new value at the fill point
    logic del; // shift entries above the hit down by one
  } cell_ctrl_t;

endpackage

### design/ist_chan_if.sv
// ist_chan_if: valid/ready channel carrying one payload struct
// payload type is supplied by the instantiating scope (see ist_pkg)
interface ist_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/ist_cell.sv
// ist_cell: one slot of the set table, holds an entry and its match flag
// depends on ist_pkg for the control struct
module ist_cell import ist_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5,
  parameter int unsigned POS_W = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cell_ctrl_t                ctrl_i,
  input  logic [CNT_W-1:0]          count_i,
  input  logic [POS_W-1:0]          hit_pos_i,
  input  logic signed [VALUE_W-1:0] cmp_value_i,
  input  logic signed [VALUE_W-1:0] ins_value_i,
  input  logic signed [VALUE_W-1:0] next_value_i,
  output logic signed [VALUE_W-1:0] value_o,
  output logic                      match_o
);

  logic signed [VALUE_W-1:0] value_q, value_d;
  logic                      match_q, match_d;
  logic                      occupied;
  logic                      shift;

  assign occupied = count_i > CNT_W'(IDX);
  // entries at or above the hit take their upper neighbor while it is occupied
  assign shift    = ctrl_i.del && (POS_W'(IDX) >= hit_pos_i) && (CNT_W'(IDX + 1) < count_i);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins && (count_i == CNT_W'(IDX))) begin
      value_d = ins_value_i;
    end else if (shift) begin
      value_d = next_value_i;
    end
  end

  assign match_d = ctrl_i.cmp ? (occupied && (value_q == cmp_value_i)) : match_q;

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

### design/integer_set_table.sv
// integer_set_table: insertion-ordered set of 32-bit signed integers
// depends on ist_pkg, ist_chan_if and ist_cell
//
// Usage: requests arrive on req_i (action, value); one response per request
// leaves on rsp_o (status, position, count). Insert appends a value that is
// not yet present, delete removes a value and closes the gap, search returns
// the position of a value.
// Each entry lives in its own cell. On the accept edge every cell compares
// its entry with the request value and registers a match flag; on the
// finishing edge, once the response slot is free, the flags are encoded to a
// position, the cells update (write at the fill point or shift down from the
// neighbor above) and the response register and rsp_o.valid load. A new
// request is taken only after the compare-then-update pass through the cells
// has finished.
// A stalled rsp_o holds the response; the next request may still be
// accepted and its match flags held until the response slot frees up.
// Reset empties the table (count 0) and clears all handshake state; entry
// contents are not cleared, only occupied cells are ever compared.
module integer_set_table import ist_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ist_chan_if.sink   req_i,
  ist_chan_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W = $clog2(CAPACITY);

  logic                      busy_q;
  logic [ACTION_W-1:0]       action_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [CNT_W-1:0]          count_q, count_d;
  rsp_t                      rsp_q, rsp_d;
  logic                      rsp_valid_q;

  logic                      req_fire;
  logic                      finish;
  cell_ctrl_t                ctrl;
  logic [CAPACITY-1:0]       match;
  logic [POS_W-1:0]          hit_pos;
  logic                      hit;
  logic signed [VALUE_W-1:0] cell_value [CAPACITY];

  assign req_i.ready = !busy_q;
  assign req_fire    = req_i.valid && req_i.ready;
  assign finish      = busy_q && (!rsp_valid_q || rsp_o.ready);

  // entries are unique, so at most one flag is set and an or-reduce encodes it
  always_comb begin
    hit_pos = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      hit_pos = hit_pos | (match[i] ? POS_W'(i) : POS_W'(0));
    end
  end
  assign hit = |match;

  always_comb begin
    ctrl     = '0;
    ctrl.cmp = req_fire;
    count_d  = count_q;
    rsp_d.status   = ST_ABSENT;
    rsp_d.position = '0;
    rsp_d.count    = '0;
    unique case (action_q)
      ACT_INSERT: begin
        if (hit) begin
          rsp_d.status   = ST_PRESENT;
          rsp_d.position = POS_OUT_W'(hit_pos);
        end else if (count_q == CNT_W'(CAPACITY)) begin
          rsp_d.status = ST_FULL;
        end else begin
          rsp_d.status   = ST_OK;
          rsp_d.position = POS_OUT_W'(count_q);
          ctrl.ins       = finish;
          count_d        = count_q + CNT_W'(1);
        end
      end
      ACT_DELETE: begin
        if (hit) begin
          rsp_d.status   = ST_OK;
          rsp_d.position = POS_OUT_W'(hit_pos);
          ctrl.del       = finish;
          count_d        = count_q - CNT_W'(1);
        end
      end
      ACT_SEARCH: begin
        if (hit) begin
          rsp_d.status   = ST_OK;
          rsp_d.position = POS_OUT_W'(hit_pos);
        end
      end
      default: begin
      end
    endcase
    rsp_d.count = COUNT_OUT_W'(count_d);
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VALUE_W-1:0] next_value;
    if (g + 1 < CAPACITY) begin : g_next
      assign next_value = cell_value[g+1];
    end else begin : g_top
      assign next_value = '0;
    end

    ist_cell #(
      .IDX   (g),
      .CNT_W (CNT_W),
      .POS_W (POS_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .hit_pos_i    (hit_pos),
      .cmp_value_i  (req_i.data.value),
      .ins_value_i  (value_q),
      .next_value_i (next_value),
      .value_o      (cell_value[g]),
      .match_o      (match[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      action_q <= req_i.data.action;
      value_q  <= req_i.data.value;
    end
    if (finish) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (req_fire) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (finish) begin
        rsp_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("more than one cell matched");

  a_rsp_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(busy_q))
    else $error("response raised without a request in flight");

  a_full_no_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CNT_W'(CAPACITY)) |-> !ctrl.ins)
    else $error("insert into full table");

endmodule
